/* rtl/tllc_pkg.sv */
// Shared types, constants and defaults for the two-level cache tag model.
`timescale 1ns / 1ps
package tllc_pkg;

    // Geometry defaults
    localparam int L1_SETS_DEF = 64;
    localparam int L1_WAYS_DEF = 4;
    localparam int L2_SETS_DEF = 256;
    localparam int L2_WAYS_DEF = 8;

    // Stored tag width: the block offset is at least one bit
    localparam int TAG_W = 31;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_SET_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_SET_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS_LOG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS_LOG = 3'd5;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic        l1_hit;
        logic        l2_accessed;
        logic        l2_hit;
        logic        mem_accessed;
        logic        l1_writeback;
        logic [31:0] l1_access_total;
        logic [31:0] l1_miss_total;
        logic [31:0] l2_access_total;
        logic [31:0] l2_miss_total;
        logic [31:0] mem_access_total;
    } t_rsp;

endpackage

/* rtl/tllc_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tllc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/two_level_lru_cache_model_unit.sv */
// Top level of the two-level write-back LRU cache tag model.
//
// Usage:
//  - Request channel (i_in_valid / o_in_ready / i_in) takes one read or write
//    address. Result channel (o_out_valid / i_out_ready / o_out) returns one
//    result per request: hit/miss flags and five saturating event counters.
//  - Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//    writes the six policy/geometry registers; always ready, use when idle.
//  - One request at a time. A request reads, updates and writes back its L1
//    set row; an L1 miss then does the same on its L2 set row, and a dirty
//    L1 victim is written into L2 by a second L2 row update. The L1 and L2
//    set memories each have a registered read.
//  - The result sits in an output register; the next request is accepted
//    while it waits. A stalled receiver holds the finished request until the
//    output register frees up.
//  - Reset clears the configuration to its defaults, the counters and a
//    per-set valid flag for each memory row; a row not yet written reads as
//    all-invalid, so no clearing pass is needed.
//  - Set counts are taken as powers of two.
`timescale 1ns / 1ps
module two_level_lru_cache_model_unit #(
    parameter int L1_SETS = tllc_pkg::L1_SETS_DEF,
    parameter int L1_WAYS = tllc_pkg::L1_WAYS_DEF,
    parameter int L2_SETS = tllc_pkg::L2_SETS_DEF,
    parameter int L2_WAYS = tllc_pkg::L2_WAYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tllc_pkg::t_req                   i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tllc_pkg::t_rsp                   o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tllc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tllc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int TW   = tllc_pkg::TAG_W;
    localparam int I1W  = L1_SETS > 1 ? $clog2(L1_SETS) : 1;
    localparam int I2W  = L2_SETS > 1 ? $clog2(L2_SETS) : 1;
    localparam int R1   = L1_WAYS > 1 ? $clog2(L1_WAYS) : 1;
    localparam int R2   = L2_WAYS > 1 ? $clog2(L2_WAYS) : 1;
    localparam int ROW1 = L1_WAYS * (TW + 2 + R1);
    localparam int ROW2 = L2_WAYS * (TW + 2 + R2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_T1   = 3'd2;
    localparam logic [2:0] S_T2   = 3'd3;
    localparam logic [2:0] S_RD3  = 3'd4;
    localparam logic [2:0] S_T3   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // Configuration registers
    logic       r_wa;
    logic [4:0] r_off;
    logic [2:0] r_s1;
    logic [3:0] r_s2;
    logic [1:0] r_w1, r_w2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa  <= 1'b1;
            r_off <= 5'd4;
            r_s1  <= 3'd2;
            r_s2  <= 4'd3;
            r_w1  <= 2'd1;
            r_w2  <= 2'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tllc_pkg::CFG_WRITE_ALLOC: r_wa  <= i_cfg_data[0];
                tllc_pkg::CFG_OFFSET_BITS: r_off <= i_cfg_data;
                tllc_pkg::CFG_L1_SET_BITS: r_s1  <= i_cfg_data[2:0];
                tllc_pkg::CFG_L2_SET_BITS: r_s2  <= i_cfg_data[3:0];
                tllc_pkg::CFG_L1_WAYS_LOG: r_w1  <= i_cfg_data[1:0];
                tllc_pkg::CFG_L2_WAYS_LOG: r_w2  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Effective split and way counts
    logic [4:0] off;
    logic [2:0] s1;
    logic [3:0] s2;
    logic [5:0] sh1, sh2;
    logic [4:0] n1, n2, n1_raw, n2_raw;

    always_comb begin
        off    = (r_off == 5'd0) ? 5'd1 : ((r_off > 5'd16) ? 5'd16 : r_off);
        s1     = (r_s1 > 3'd6) ? 3'd6 : r_s1;
        s2     = (r_s2 > 4'd8) ? 4'd8 : r_s2;
        sh1    = 6'(off) + 6'(s1);
        sh2    = 6'(off) + 6'(s2);
        n1_raw = 5'd1 << ((r_w1 > 2'd2) ? 2'd2 : r_w1);
        n2_raw = 5'd1 << r_w2;
        n1     = (n1_raw > 5'(L1_WAYS)) ? 5'(L1_WAYS) : n1_raw;
        n2     = (n2_raw > 5'(L2_WAYS)) ? 5'(L2_WAYS) : n2_raw;
    end

    // Control and request registers
    logic [2:0]    r_state;
    logic          r_cmd;
    logic [TW-1:0] r_tag1, r_tag2, r_vt1, r_vt2;
    logic [7:0]    r_set1, r_set2, r_vs2;
    logic          r_h1, r_h2, r_rep, r_vdirty;
    logic [31:0]   r_cnt [5];
    logic [L1_SETS-1:0] r_l1_ok;
    logic [L2_SETS-1:0] r_l2_ok;
    logic          r_ov;
    tllc_pkg::t_rsp r_out;

    // Address split of the incoming request
    logic [31:0] a_sh;
    logic [7:0]  in_set1, in_set2;
    logic [31:0] in_tag1, in_tag2;
    always_comb begin
        a_sh    = i_in.address >> off;
        in_set1 = 8'(a_sh & ((32'd1 << s1) - 32'd1));
        in_set2 = 8'(a_sh & ((32'd1 << s2) - 32'd1));
        in_tag1 = i_in.address >> sh1;
        in_tag2 = i_in.address >> sh2;
    end

    // Victim address rebuilt into its L2 set and tag
    logic [31:0] vaddr, v_sh, v_tag2;
    always_comb begin
        vaddr  = ({1'b0, r_vt1} << sh1) | (32'(r_set1) << off);
        v_sh   = vaddr >> off;
        v_tag2 = vaddr >> sh2;
    end

    function automatic logic [I1W-1:0] idx1(input logic [7:0] s);
        return (L1_SETS == 1) ? '0 : I1W'(s);
    endfunction
    function automatic logic [I2W-1:0] idx2(input logic [7:0] s);
        return (L2_SETS == 1) ? '0 : I2W'(s);
    endfunction

    // Set memories
    logic [ROW1-1:0] l1_rd, l1_wd;
    logic [ROW2-1:0] l2_rd, l2_wd;
    logic [I1W-1:0]  l1_idx;
    logic [I2W-1:0]  l2_idx, l2_ridx;
    logic            l1_we, l2_we;

    assign l1_idx  = idx1(r_set1);
    assign l2_idx  = (r_state == S_T3) ? idx2(r_vs2) : idx2(r_set2);
    assign l2_ridx = (r_state == S_RD3) ? idx2(r_vs2) : idx2(r_set2);
    assign l1_we   = (r_state == S_T1);
    assign l2_we   = (r_state == S_T2) || (r_state == S_T3);

    tllc_ram #(.WIDTH(ROW1), .DEPTH(L1_SETS)) u_l1_ram (
        .i_clk(i_clk), .i_we(l1_we), .i_waddr(l1_idx), .i_wdata(l1_wd),
        .i_raddr(l1_idx), .o_rdata(l1_rd)
    );
    tllc_ram #(.WIDTH(ROW2), .DEPTH(L2_SETS)) u_l2_ram (
        .i_clk(i_clk), .i_we(l2_we), .i_waddr(l2_idx), .i_wdata(l2_wd),
        .i_raddr(l2_ridx), .o_rdata(l2_rd)
    );

    // L1 set update: lookup, allocate, LRU rank update
    logic [L1_WAYS-1:0][TW-1:0] tg1, ntg1;
    logic [L1_WAYS-1:0]         vb1, db1, nvb1, ndb1;
    logic [L1_WAYS-1:0][R1-1:0] rk1, nrk1;
    logic [R1-1:0]              old1;
    logic [R1-1:0]              hw1, iw1, bw1, sw1;
    logic                       hit1, inv1, mod1, rep1, wr1;

    always_comb begin
        {rk1, db1, vb1, tg1} = r_l1_ok[l1_idx] ? l1_rd : '0;
        wr1  = (r_cmd == tllc_pkg::CMD_WRITE);
        hit1 = 1'b0; inv1 = 1'b0;
        hw1  = '0;   iw1  = '0;  bw1 = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (5'(w) < n1) begin
                if (!hit1 && vb1[w] && tg1[w] == r_tag1) begin
                    hit1 = 1'b1; hw1 = R1'(w);
                end
                if (!inv1 && !vb1[w]) begin
                    inv1 = 1'b1; iw1 = R1'(w);
                end
                if (rk1[w] < rk1[bw1]) bw1 = R1'(w);
            end
        end
        mod1 = hit1 || !(wr1 && !r_wa);
        sw1  = hit1 ? hw1 : (inv1 ? iw1 : bw1);
        rep1 = !hit1 && mod1 && !inv1;
        old1 = hit1 ? rk1[sw1] : '0;
        ntg1 = tg1; nvb1 = vb1; ndb1 = db1; nrk1 = rk1;
        if (mod1) begin
            for (int j = 0; j < L1_WAYS; j++) begin
                if (R1'(j) == sw1) begin
                    nrk1[j] = R1'(n1 - 5'd1);
                end else if (5'(j) < n1 && rk1[j] > old1) begin
                    nrk1[j] = rk1[j] - 1'b1;
                end
            end
            if (hit1) begin
                if (wr1) ndb1[sw1] = 1'b1;
            end else begin
                ntg1[sw1] = r_tag1;
                nvb1[sw1] = 1'b1;
                ndb1[sw1] = wr1;
            end
        end
        l1_wd = {nrk1, ndb1, nvb1, ntg1};
    end

    // L2 set update, shared by the request and the victim writeback
    logic [L2_WAYS-1:0][TW-1:0] tg2, ntg2;
    logic [L2_WAYS-1:0]         vb2, db2, nvb2, ndb2;
    logic [L2_WAYS-1:0][R2-1:0] rk2, nrk2;
    logic [R2-1:0]              old2;
    logic [R2-1:0]              hw2, iw2, bw2, sw2;
    logic                       hit2, inv2, mod2, wr2, al2, ok2;
    logic [TW-1:0]              key2;

    always_comb begin
        ok2 = (r_state == S_T3) ? r_l2_ok[idx2(r_vs2)] : r_l2_ok[idx2(r_set2)];
        {rk2, db2, vb2, tg2} = ok2 ? l2_rd : '0;
        if (r_state == S_T3) begin
            key2 = r_vt2; wr2 = 1'b1; al2 = r_wa;
        end else begin
            key2 = r_tag2;
            wr2  = (r_cmd == tllc_pkg::CMD_WRITE) && !r_wa;
            al2  = !wr2;
        end
        hit2 = 1'b0; inv2 = 1'b0;
        hw2  = '0;   iw2  = '0;  bw2 = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (5'(w) < n2) begin
                if (!hit2 && vb2[w] && tg2[w] == key2) begin
                    hit2 = 1'b1; hw2 = R2'(w);
                end
                if (!inv2 && !vb2[w]) begin
                    inv2 = 1'b1; iw2 = R2'(w);
                end
                if (rk2[w] < rk2[bw2]) bw2 = R2'(w);
            end
        end
        mod2 = hit2 || !(wr2 && !al2);
        sw2  = hit2 ? hw2 : (inv2 ? iw2 : bw2);
        old2 = hit2 ? rk2[sw2] : '0;
        ntg2 = tg2; nvb2 = vb2; ndb2 = db2; nrk2 = rk2;
        if (mod2) begin
            for (int j = 0; j < L2_WAYS; j++) begin
                if (R2'(j) == sw2) begin
                    nrk2[j] = R2'(n2 - 5'd1);
                end else if (5'(j) < n2 && rk2[j] > old2) begin
                    nrk2[j] = rk2[j] - 1'b1;
                end
            end
            if (hit2) begin
                if (wr2) ndb2[sw2] = 1'b1;
            end else begin
                ntg2[sw2] = key2;
                nvb2[sw2] = 1'b1;
                ndb2[sw2] = wr2;
            end
        end
        l2_wd = {nrk2, ndb2, nvb2, ntg2};
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == tllc_pkg::CNT_MAX) ? v : v + 32'd1;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_l1_ok <= '0;
            r_l2_ok <= '0;
            for (int k = 0; k < 5; k++) r_cnt[k] <= '0;
        end else begin
            // result taken; the finishing state reloads it itself
            if (r_ov && i_out_ready && r_state != S_DONE) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in.command;
                        r_set1  <= in_set1;
                        r_set2  <= in_set2;
                        r_tag1  <= in_tag1[TW-1:0];
                        r_tag2  <= in_tag2[TW-1:0];
                        r_state <= S_RD1;
                    end
                end
                S_RD1: r_state <= S_T1;
                S_T1: begin
                    r_l1_ok[l1_idx] <= 1'b1;
                    r_h1     <= hit1;
                    r_h2     <= 1'b0;
                    r_rep    <= rep1;
                    r_vt1    <= tg1[bw1];
                    r_vdirty <= db1[bw1];
                    r_cnt[0] <= sat_inc(r_cnt[0]);
                    if (!hit1) begin
                        r_cnt[1] <= sat_inc(r_cnt[1]);
                        r_cnt[2] <= sat_inc(r_cnt[2]);
                    end
                    r_state <= hit1 ? S_DONE : S_T2;
                end
                S_T2: begin
                    r_l2_ok[idx2(r_set2)] <= 1'b1;
                    r_h2  <= hit2;
                    r_vs2 <= 8'(v_sh & ((32'd1 << s2) - 32'd1));
                    r_vt2 <= v_tag2[TW-1:0];
                    if (!hit2) begin
                        r_cnt[3] <= sat_inc(r_cnt[3]);
                        r_cnt[4] <= sat_inc(r_cnt[4]);
                    end
                    r_state <= (r_rep && r_vdirty) ? S_RD3 : S_DONE;
                end
                S_RD3: r_state <= S_T3;
                S_T3: begin
                    r_l2_ok[idx2(r_vs2)] <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov                   <= 1'b1;
                        r_out.l1_hit           <= r_h1;
                        r_out.l2_accessed      <= !r_h1;
                        r_out.l2_hit           <= r_h2;
                        r_out.mem_accessed     <= !r_h1 && !r_h2;
                        r_out.l1_writeback     <= !r_h1 && r_rep && r_vdirty;
                        r_out.l1_access_total  <= r_cnt[0];
                        r_out.l1_miss_total    <= r_cnt[1];
                        r_out.l2_access_total  <= r_cnt[2];
                        r_out.l2_miss_total    <= r_cnt[3];
                        r_out.mem_access_total <= r_cnt[4];
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/tllc_checker.sv */
// Port-level checker for the cache tag model, bound to the top level.
`timescale 1ns / 1ps
module tllc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input tllc_pkg::t_rsp o_out
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // An L1 hit never goes further
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.l1_hit |-> !o_out.l2_accessed && !o_out.l1_writeback)
        else $error("L1 hit reported L2 activity");

    // Memory is reached exactly on an L2 miss
    a_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.mem_accessed == (o_out.l2_accessed && !o_out.l2_hit))
        else $error("memory flag mismatch");

    // Misses never outrun accesses
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.l1_miss_total <= o_out.l1_access_total
                     && o_out.l2_miss_total <= o_out.l2_access_total)
        else $error("miss count above access count");

endmodule

bind two_level_lru_cache_model_unit tllc_checker u_tllc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out(o_out)
);
